[rtl/core/v3a_pkg.sv]
package v3a_pkg;

   localparam int QBITS    = 32;
   localparam int SQRT_LAT = QBITS + 1;
   localparam int DIV_LAT  = QBITS + 1;
   localparam int PIPE_LAT = 4 + SQRT_LAT + DIV_LAT + 1;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_SCALE = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_DOT   = 4'd5;
   localparam logic [3:0] OP_CROSS = 4'd6;
   localparam logic [3:0] OP_MAG   = 4'd7;
   localparam logic [3:0] OP_NORM  = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by_comp;
      logic signed [31:0] bz;
      logic signed [31:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] scalar_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] pa;
      logic signed [31:0] pb;
      logic signed [31:0] qa;
      logic signed [31:0] qb;
   } lane_in_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] x);
      sat_type r;
      if (x > Q_MAX64) begin
         r.v   = 32'sh7FFF_FFFF;
         r.ovf = 1'b1;
      end else if (x < Q_MIN64) begin
         r.v   = 32'sh8000_0000;
         r.ovf = 1'b1;
      end else begin
         r.v   = x[31:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // apply sign to an unsigned quotient and clamp
   function automatic sat_type sat_quot(input logic [31:0] q, input logic neg,
                                        input logic ovf);
      sat_type r;
      if (ovf || (!neg && q[31]) || (neg && q > 32'h8000_0000)) begin
         r.v   = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         r.ovf = 1'b1;
      end else begin
         r.v   = neg ? $signed(~q + 32'd1) : $signed(q);
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/core/v3a_lane.sv]
module v3a_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  v3a_pkg::lane_in_type lane_in,
   output logic signed [63:0]   lane_val
);

   logic signed [63:0] p_ff, p_in;
   logic signed [63:0] q_ff, q_in;
   logic signed [32:0] sd_ff, sd_in;
   logic [3:0]         op_ff, op_in;
   logic signed [63:0] val_ff, val_in;

   function automatic logic signed [63:0] qround(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [63:0] m;
      mag = x[63] ? (~x + 64'd1) : x;
      m   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return x[63] ? $signed(~m + 64'd1) : $signed(m);
   endfunction

   assign p_in  = 64'(lane_in.pa) * 64'(lane_in.pb);
   assign q_in  = 64'(lane_in.qa) * 64'(lane_in.qb);
   assign sd_in = (lane_in.op == v3a_pkg::OP_SUB) ? 33'(lane_in.a) - 33'(lane_in.b)
                                                  : 33'(lane_in.a) + 33'(lane_in.b);
   assign op_in = lane_in.op;

   always_comb begin
      case (op_ff)
         v3a_pkg::OP_ADD, v3a_pkg::OP_SUB: val_in = 64'(sd_ff);
         v3a_pkg::OP_MUL, v3a_pkg::OP_SCALE, v3a_pkg::OP_DOT: val_in = qround(p_ff);
         v3a_pkg::OP_CROSS: val_in = qround(p_ff) - qround(q_ff);
         v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: val_in = p_ff;
         default: val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      q_ff   <= q_in;
      sd_ff  <= sd_in;
      op_ff  <= op_in;
      val_ff <= val_in;
   end

   assign lane_val = val_ff;

endmodule

[rtl/core/v3a_sqrt.sv]
module v3a_sqrt (
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   localparam int N  = v3a_pkg::QBITS;
   localparam int RW = N + 2;

   logic [63:0]   x_src    [0:N];
   logic [RW-1:0] rem_src  [0:N];
   logic [N-1:0]  root_src [0:N];
   logic [63:0]   x_ff     [0:N-1];
   logic [RW-1:0] rem_ff   [0:N-1];
   logic [N-1:0]  root_ff  [0:N-1];
   logic [N-1:0]  m_ff, m_in;

   assign x_src[0]    = radicand;
   assign rem_src[0]  = '0;
   assign root_src[0] = '0;

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [RW+1:0] remn;
      logic [RW+1:0] trial;
      logic          ge;
      logic [63:0]   x_in;
      logic [RW-1:0] rem_in;
      logic [N-1:0]  root_in;

      assign remn    = {rem_src[j], x_src[j][63:62]};
      assign trial   = {2'b00, root_src[j], 2'b01};
      assign ge      = remn >= trial;
      assign rem_in  = ge ? RW'(remn - trial) : RW'(remn);
      assign root_in = {root_src[j][N-2:0], ge};
      assign x_in    = {x_src[j][61:0], 2'b00};

      always_ff @(posedge clock) begin
         x_ff[j]    <= x_in;
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end

      assign x_src[j+1]    = x_ff[j];
      assign rem_src[j+1]  = rem_ff[j];
      assign root_src[j+1] = root_ff[j];
   end

   // round up when the remainder exceeds the floor root
   assign m_in = root_src[N] + N'(rem_src[N] > {2'b00, root_src[N]});

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   assign root = m_ff;

endmodule

[rtl/core/v3a_div.sv]
module v3a_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic [31:0] num,
   input  logic [31:0] den,
   input  logic        neg,
   output logic [31:0] quot,
   output logic        quot_neg,
   output logic        quot_ovf
);

   localparam int N = v3a_pkg::QBITS;

   logic [63:0]  n_in;
   logic         ovf_in;
   logic [63:0]  rem_src [0:N];
   logic [N-1:0] q_src   [0:N];
   logic [31:0]  d_src   [0:N];
   logic         neg_src [0:N];
   logic         ovf_src [0:N];
   logic [63:0]  rem_ff  [0:N];
   logic [N-1:0] q_ff    [0:N];
   logic [31:0]  d_ff    [0:N];
   logic         neg_ff  [0:N];
   logic         ovf_ff  [0:N];

   // bias by half the divisor so the truncated quotient rounds to nearest
   assign n_in   = ({32'd0, num} << FRAC_BITS) + {33'd0, den[31:1]};
   assign ovf_in = n_in >= {den, 32'd0};

   always_ff @(posedge clock) begin
      rem_ff[0] <= n_in;
      q_ff[0]   <= '0;
      d_ff[0]   <= den;
      neg_ff[0] <= neg;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar j = 0; j <= N; j++) begin : g_src
      assign rem_src[j] = rem_ff[j];
      assign q_src[j]   = q_ff[j];
      assign d_src[j]   = d_ff[j];
      assign neg_src[j] = neg_ff[j];
      assign ovf_src[j] = ovf_ff[j];
   end

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [63:0] dk;
      logic        ge;

      assign dk = {32'd0, d_src[j]} << (N - 1 - j);
      assign ge = rem_src[j] >= dk;

      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? rem_src[j] - dk : rem_src[j];
         q_ff[j+1]   <= {q_src[j][N-2:0], ge};
         d_ff[j+1]   <= d_src[j];
         neg_ff[j+1] <= neg_src[j];
         ovf_ff[j+1] <= ovf_src[j];
      end
   end

   assign quot     = q_src[N];
   assign quot_neg = neg_src[N];
   assign quot_ovf = ovf_src[N];

endmodule

[rtl/core/vector3_alu_unit.sv]
// Three-component vector unit in signed fixed point (FRAC_BITS fraction bits in 32).
// A request is taken in any cycle that start is high; busy never rises, so one request
// per clock is sustained. Every request returns exactly one response, whatever the
// opcode, after operand select, lane multiply and merge, the bit-per-stage square
// root, the bit-per-stage dividers (one per component) and the output register. The
// response is shown for one cycle with rsp_strobe and cannot be held off by the receiver.
// Overflow saturates with status 1; divide by zero or normalizing a zero vector gives
// zeros with status 2; unknown opcodes return zeros with status 0.
module vector3_alu_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  v3a_pkg::req_type req_data,
   output logic             rsp_strobe,
   output v3a_pkg::rsp_type rsp_data
);

   localparam int LS  = v3a_pkg::SQRT_LAT;
   localparam int LD  = v3a_pkg::DIV_LAT;
   localparam int LAT = v3a_pkg::PIPE_LAT;

   typedef struct packed {
      logic [3:0]       op;
      logic             dz;
      v3a_pkg::rsp_type early;
   } side_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] s;
   } opnd_type;

   logic [LAT-1:0]          vld_ff;
   v3a_pkg::req_type        req_ff [0:2];
   logic signed [31:0]      av [0:2];
   logic signed [31:0]      bv [0:2];
   logic signed [63:0]      lane_val [0:2];
   side_type                side_ff [0:LS+LD];
   side_type                side_in;
   opnd_type                opnd_ff [0:LS];
   opnd_type                opnd_in;
   logic [63:0]             sq_ff, sq_in;
   logic [31:0]             m_root;
   logic [31:0]             m_ff [0:LD-1];
   logic signed [31:0]      div_a [0:2];
   logic [31:0]             den;
   logic [31:0]             quot [0:2];
   logic                    quot_neg [0:2];
   logic                    quot_ovf [0:2];
   v3a_pkg::sat_type        dq [0:2];
   v3a_pkg::rsp_type        rsp_ff, rsp_in;
   side_type                side_end;

   assign busy = 1'b0;

   // request and valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      req_ff[0] <= req_data;
      req_ff[1] <= req_ff[0];
      req_ff[2] <= req_ff[1];
   end

   assign av[0] = req_ff[0].ax;
   assign av[1] = req_ff[0].ay;
   assign av[2] = req_ff[0].az;
   assign bv[0] = req_ff[0].bx;
   assign bv[1] = req_ff[0].by_comp;
   assign bv[2] = req_ff[0].bz;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3a_pkg::lane_in_type lane_in;

      always_comb begin
         lane_in.op = req_ff[0].op;
         lane_in.a  = av[i];
         lane_in.b  = bv[i];
         lane_in.pa = av[i];
         lane_in.pb = bv[i];
         lane_in.qa = '0;
         lane_in.qb = '0;
         case (req_ff[0].op)
            v3a_pkg::OP_SCALE: lane_in.pb = req_ff[0].scalar_in;
            v3a_pkg::OP_CROSS: begin
               lane_in.pa = av[(i + 1) % 3];
               lane_in.pb = bv[(i + 2) % 3];
               lane_in.qa = av[(i + 2) % 3];
               lane_in.qb = bv[(i + 1) % 3];
            end
            v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: lane_in.pb = av[i];
            default: lane_in.pb = bv[i];
         endcase
      end

      v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock    (clock),
         .lane_in  (lane_in),
         .lane_val (lane_val[i])
      );
   end

   // merge lanes
   always_comb begin
      v3a_pkg::sat_type s0, s1, s2, sd;
      s0 = v3a_pkg::sat32(lane_val[0]);
      s1 = v3a_pkg::sat32(lane_val[1]);
      s2 = v3a_pkg::sat32(lane_val[2]);
      sd = v3a_pkg::sat32(lane_val[0] + lane_val[1] + lane_val[2]);
      side_in.op    = req_ff[2].op;
      side_in.dz    = (req_ff[2].op == v3a_pkg::OP_DIV) && (req_ff[2].scalar_in == '0);
      side_in.early = '0;
      case (req_ff[2].op)
         v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_MUL, v3a_pkg::OP_SCALE,
         v3a_pkg::OP_CROSS: begin
            side_in.early.rx     = s0.v;
            side_in.early.ry     = s1.v;
            side_in.early.rz     = s2.v;
            side_in.early.status = (s0.ovf || s1.ovf || s2.ovf) ? v3a_pkg::ST_SAT
                                                                : v3a_pkg::ST_OK;
         end
         v3a_pkg::OP_DOT: begin
            side_in.early.scalar_out = sd.v;
            side_in.early.status     = sd.ovf ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
         end
         default: side_in.early = '0;
      endcase
   end

   assign sq_in = $unsigned(lane_val[0]) + $unsigned(lane_val[1]) + $unsigned(lane_val[2]);

   assign opnd_in.ax = req_ff[2].ax;
   assign opnd_in.ay = req_ff[2].ay;
   assign opnd_in.az = req_ff[2].az;
   assign opnd_in.s  = req_ff[2].scalar_in;

   always_ff @(posedge clock) begin
      sq_ff      <= sq_in;
      side_ff[0] <= side_in;
      opnd_ff[0] <= opnd_in;
      for (int k = 1; k <= LS + LD; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      for (int k = 1; k <= LS; k++) begin
         opnd_ff[k] <= opnd_ff[k-1];
      end
      m_ff[0] <= m_root;
      for (int k = 1; k < LD; k++) begin
         m_ff[k] <= m_ff[k-1];
      end
   end

   v3a_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sq_ff),
      .root     (m_root)
   );

   // divisor is |s| for divide, the rounded magnitude for normalize
   assign den = (side_ff[LS].op == v3a_pkg::OP_DIV)
                ? (opnd_ff[LS].s[31] ? ~opnd_ff[LS].s + 32'd1 : opnd_ff[LS].s)
                : m_root;

   assign div_a[0] = opnd_ff[LS].ax;
   assign div_a[1] = opnd_ff[LS].ay;
   assign div_a[2] = opnd_ff[LS].az;

   for (genvar i = 0; i < 3; i++) begin : g_div
      logic [31:0] num;
      logic        neg;

      assign num = div_a[i][31] ? ~div_a[i] + 32'd1 : div_a[i];
      assign neg = div_a[i][31] ^ ((side_ff[LS].op == v3a_pkg::OP_DIV) && opnd_ff[LS].s[31]);

      v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock    (clock),
         .num      (num),
         .den      (den),
         .neg      (neg),
         .quot     (quot[i]),
         .quot_neg (quot_neg[i]),
         .quot_ovf (quot_ovf[i])
      );

      assign dq[i] = v3a_pkg::sat_quot(quot[i], quot_neg[i], quot_ovf[i]);
   end

   assign side_end = side_ff[LS+LD];

   always_comb begin
      rsp_in = side_end.early;
      case (side_end.op)
         v3a_pkg::OP_DIV, v3a_pkg::OP_NORM: begin
            rsp_in = '0;
            if (side_end.dz || (side_end.op == v3a_pkg::OP_NORM && m_ff[LD-1] == '0)) begin
               rsp_in.status = v3a_pkg::ST_ZERO;
            end else begin
               rsp_in.rx     = dq[0].v;
               rsp_in.ry     = dq[1].v;
               rsp_in.rz     = dq[2].v;
               rsp_in.status = (dq[0].ovf || dq[1].ovf || dq[2].ovf) ? v3a_pkg::ST_SAT
                                                                     : v3a_pkg::ST_OK;
            end
         end
         v3a_pkg::OP_MAG: begin
            rsp_in            = '0;
            rsp_in.scalar_out = m_ff[LD-1][31] ? 32'sh7FFF_FFFF : $signed(m_ff[LD-1]);
            rsp_in.status     = m_ff[LD-1][31] ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
         end
         default: rsp_in = side_end.early;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = vld_ff[LAT-1];

endmodule

[rtl/core/v3a_checker.sv]
module v3a_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input v3a_pkg::req_type req_data,
   input logic             rsp_strobe,
   input v3a_pkg::rsp_type rsp_data
);

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(v3a_pkg::PIPE_LAT) rsp_strobe)
      else $error("request lost");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, v3a_pkg::PIPE_LAT))
      else $error("response without request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status != 2'd3))
      else $error("bad status");

   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == v3a_pkg::ST_ZERO) |->
      (rsp_data.rx == '0 && rsp_data.ry == '0 && rsp_data.rz == '0 &&
       rsp_data.scalar_out == '0))
      else $error("nonzero result on divide fault");

   a_unknown_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.op, v3a_pkg::PIPE_LAT) > v3a_pkg::OP_NORM) |->
      (rsp_data.rx == '0 && rsp_data.ry == '0 && rsp_data.rz == '0 &&
       rsp_data.scalar_out == '0 && rsp_data.status == v3a_pkg::ST_OK))
      else $error("unknown opcode gave a result");

endmodule

bind vector3_alu_unit v3a_checker u_v3a_checker (.*);

[tb/vector3_alu_unit_tb.sv]
`timescale 1ns / 100ps

module vector3_alu_unit_tb;
   import v3a_pkg::*;

   localparam int FB = 16;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int TAIL = PIPE_LAT + 20;
   localparam int LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   vector3_alu_unit #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      send_idle_pct = 0;
   bit      hold_send = 0;
   int      mismatches = 0;
   longint  cycles = 0;

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (abs64(p) + (64'sd1 <<< (FB - 1))) >>> FB;
      return p < 0 ? -m : m;
   endfunction

   function automatic longint fx_div(longint a, longint d, bit neg_d);
      longint unsigned n, q;
      n = longint'(abs64(a)) << FB;
      q = (n + d / 2) / d;
      return ((a < 0) != neg_d) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [31:0] clamp(longint v, ref logic [1:0] st);
      if (v > QMAX) begin
         st = ST_SAT;
         return 32'h7FFF_FFFF;
      end
      if (v < QMIN) begin
         st = ST_SAT;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic longint unsigned root_round(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      if (x > r) r++;
      return r;
   endfunction

   function automatic rsp_type vector_result(req_type q);
      rsp_type o;
      longint a[3], b[3], s;
      logic [1:0] st;
      longint unsigned sq, m;
      a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
      b[0] = q.bx; b[1] = q.by_comp; b[2] = q.bz;
      s = q.scalar_in;
      o = '0;
      st = ST_OK;
      case (q.op)
         OP_ADD: begin
            o.rx = clamp(a[0] + b[0], st); o.ry = clamp(a[1] + b[1], st);
            o.rz = clamp(a[2] + b[2], st);
         end
         OP_SUB: begin
            o.rx = clamp(a[0] - b[0], st); o.ry = clamp(a[1] - b[1], st);
            o.rz = clamp(a[2] - b[2], st);
         end
         OP_MUL: begin
            o.rx = clamp(fx_mul(a[0], b[0]), st); o.ry = clamp(fx_mul(a[1], b[1]), st);
            o.rz = clamp(fx_mul(a[2], b[2]), st);
         end
         OP_SCALE: begin
            o.rx = clamp(fx_mul(a[0], s), st); o.ry = clamp(fx_mul(a[1], s), st);
            o.rz = clamp(fx_mul(a[2], s), st);
         end
         OP_DIV: begin
            if (s == 0) st = ST_ZERO;
            else begin
               o.rx = clamp(fx_div(a[0], abs64(s), s < 0), st);
               o.ry = clamp(fx_div(a[1], abs64(s), s < 0), st);
               o.rz = clamp(fx_div(a[2], abs64(s), s < 0), st);
            end
         end
         OP_DOT: o.scalar_out = clamp(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1])
                                      + fx_mul(a[2], b[2]), st);
         OP_CROSS: begin
            o.rx = clamp(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), st);
            o.ry = clamp(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), st);
            o.rz = clamp(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), st);
         end
         OP_MAG, OP_NORM: begin
            sq = 0;
            for (int i = 0; i < 3; i++) sq += longint'(abs64(a[i])) * longint'(abs64(a[i]));
            m = root_round(sq);
            if (q.op == OP_MAG) o.scalar_out = clamp(longint'(m), st);
            else if (m == 0) st = ST_ZERO;
            else begin
               o.rx = clamp(fx_div(a[0], m, 1'b0), st);
               o.ry = clamp(fx_div(a[1], m, 1'b0), st);
               o.rz = clamp(fx_div(a[2], m, 1'b0), st);
            end
         end
         default: ;
      endcase
      o.status = st;
      return o;
   endfunction

   // driver: hold start high across back-to-back requests
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(vector_result(req_data));
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0 && !hold_send
             && $urandom_range(99) >= send_idle_pct) begin
            start <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h %h %0d, got %h %h %h %h %0d",
                           e.rx, e.ry, e.rz, e.scalar_out, e.status, rsp_data.rx,
                           rsp_data.ry, rsp_data.rz, rsp_data.scalar_out, rsp_data.status);
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(8'hFF)) - 128) <<< FB;
         2: return $urandom_range(3) == 0 ? 32'd0 : $urandom_range(65535);
         3: return 32'($signed($urandom & 32'h00FF_FFFF) - 32'sh0080_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(logic [3:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] u, logic [31:0] v, logic [31:0] w, logic [31:0] s);
      req_type q;
      q.op = op; q.ax = x; q.ay = y; q.az = z;
      q.bx = u; q.by_comp = v; q.bz = w; q.scalar_in = s;
      pending_reqs.push_back(q);
   endtask

   task automatic push_random(int n);
      logic [3:0] op;
      repeat (n) begin
         op = $urandom_range(15) < 14 ? 4'($urandom_range(8)) : 4'($urandom_range(15));
         push_req(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), $urandom_range(15) == 0 ? 32'd0 : rand_comp());
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      localparam logic [31:0] MX = 32'h7FFF_FFFF, MN = 32'h8000_0000, ONE = 32'h0001_0000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: every op, extremes, divide by zero, zero vector, unknown op
      for (int op = 0; op <= 8; op++) push_req(4'(op), MX, MN, ONE, MX, MN, 32'hFFFF_0000, MN);
      push_req(OP_DIV, ONE, MX, MN, 0, 0, 0, 32'd0);
      push_req(OP_DIV, MN, MX, ONE, 0, 0, 0, 32'd1);
      push_req(OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE);
      push_req(OP_NORM, MN, 0, 0, 0, 0, 0, 0);
      push_req(OP_MAG, MN, MN, MN, 0, 0, 0, 0);
      push_req(OP_MAG, 0, 0, 0, 0, 0, 0, 0);
      push_req(OP_SCALE, 32'h8000, 32'hFFFF_8000, 1, 0, 0, 0, 32'h8000);
      push_req(OP_DOT, MX, MX, MX, MX, MX, MX, 0);
      push_req(OP_CROSS, MN, MX, MN, MX, MN, MX, 0);
      push_req(4'd9, MX, MX, MX, MX, MX, MX, MX);
      push_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_idle_pct = 19;
      push_random(600);
      drain();
      // pause sending while requests are queued
      hold_send = 1;
      push_random(20);
      repeat (2 * PIPE_LAT) @(posedge clock);
      hold_send = 0;
      send_idle_pct = 80;
      push_random(580);
      drain();
      send_idle_pct = 0;
      push_random(600);
      drain();
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
